// ===== sv/afr_pkg.sv =====
// Shared types and constants for the API frame receiver.
package afr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        EV_BUSY,
        EV_SKIPPED,
        EV_LINE_ERROR,
        EV_OVERRUN,
        EV_GOOD,
        EV_BAD_SUM
    } event_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] kind;
    } step_res_t;

    localparam int STAT_COUNT = 7;
    localparam int ST_SKIPPED = 0;
    localparam int ST_ERROR   = 1;
    localparam int ST_OVERRUN = 2;
    localparam int ST_BADSUM  = 3;
    localparam int ST_UNKNOWN = 4;
    localparam int ST_RETRY   = 5;
    localparam int ST_LOST    = 6;

    localparam logic [7:0]  DELIM          = 8'h7e;
    localparam logic [7:0]  KIND_TX_STATUS = 8'h8b;
    localparam logic [7:0]  SUM_BASE       = 8'hff;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd255;

    localparam logic [15:0] IDX_KIND   = 16'd0;
    localparam logic [15:0] IDX_RETRY  = 16'd4;
    localparam logic [15:0] IDX_STATUS = 16'd5;

endpackage

// ===== sv/afr_parser.sv =====
// Frame parsing state machine and statistics counters.
module afr_parser
    import afr_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               rx_byte,
    input  logic                     line_error,
    input  logic [15:0]              max_len,
    output step_res_t                res,
    output logic [COUNTER_WIDTH-1:0] cnt_next [STAT_COUNT]
);

    phase_t                   phase_reg, phase_next;
    logic [15:0]              len_reg, len_next;
    logic [15:0]              seen_reg, seen_next;
    logic [7:0]               sum_reg, sum_next;
    logic [7:0]               kind_reg, kind_next;
    logic [7:0]               retry_reg, retry_next;
    logic [7:0]               status_reg, status_next;
    logic [COUNTER_WIDTH-1:0] cnt_reg [STAT_COUNT];
    logic [15:0]              full_len;

    assign full_len = {len_reg[15:8], rx_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_reg    <= '0;
            seen_reg   <= '0;
            sum_reg    <= '0;
            kind_reg   <= '0;
            retry_reg  <= '0;
            status_reg <= '0;
            for (int i = 0; i < STAT_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            sum_reg    <= sum_next;
            kind_reg   <= kind_next;
            retry_reg  <= retry_next;
            status_reg <= status_next;
            for (int i = 0; i < STAT_COUNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        sum_next    = sum_reg;
        kind_next   = kind_reg;
        retry_next  = retry_reg;
        status_next = status_reg;
        for (int i = 0; i < STAT_COUNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        res.ev   = EV_BUSY;
        res.kind = '0;

        if (step)
        begin
            if (line_error)
            begin
                cnt_next[ST_ERROR] = cnt_reg[ST_ERROR] + 1'b1;
                phase_next         = PH_IDLE;
                res.ev             = EV_LINE_ERROR;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (rx_byte != DELIM)
                        begin
                            cnt_next[ST_SKIPPED] = cnt_reg[ST_SKIPPED] + 1'b1;
                            res.ev               = EV_SKIPPED;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                            len_next   = '0;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        len_next   = {rx_byte, 8'h00};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        len_next = full_len;
                        if (full_len > max_len)
                        begin
                            cnt_next[ST_OVERRUN] = cnt_reg[ST_OVERRUN] + 1'b1;
                            cnt_next[ST_ERROR]   = cnt_reg[ST_ERROR] + 1'b1;
                            phase_next           = PH_IDLE;
                            res.ev               = EV_OVERRUN;
                        end
                        else
                        begin
                            seen_next   = '0;
                            sum_next    = '0;
                            kind_next   = '0;
                            retry_next  = '0;
                            status_next = '0;
                            phase_next  = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (seen_reg < len_reg)
                        begin
                            sum_next = sum_reg + rx_byte;
                            if (seen_reg == IDX_KIND)
                            begin
                                kind_next = rx_byte;
                            end
                            else if (seen_reg == IDX_RETRY)
                            begin
                                retry_next = rx_byte;
                            end
                            else if (seen_reg == IDX_STATUS)
                            begin
                                status_next = rx_byte;
                            end
                            seen_next = seen_reg + 16'd1;
                        end
                        else
                        begin
                            if ((SUM_BASE - sum_reg) == rx_byte)
                            begin
                                res.ev = EV_GOOD;
                            end
                            else
                            begin
                                res.ev              = EV_BAD_SUM;
                                cnt_next[ST_BADSUM] = cnt_reg[ST_BADSUM] + 1'b1;
                            end
                            res.kind = kind_reg;
                            if (kind_reg == KIND_TX_STATUS)
                            begin
                                cnt_next[ST_RETRY] = cnt_reg[ST_RETRY]
                                                   + COUNTER_WIDTH'(retry_reg);
                                if (status_reg != 8'h00)
                                begin
                                    cnt_next[ST_LOST] = cnt_reg[ST_LOST] + 1'b1;
                                end
                            end
                            else
                            begin
                                cnt_next[ST_UNKNOWN] = cnt_reg[ST_UNKNOWN] + 1'b1;
                            end
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/api_frame_receiver_unit.sv =====
// Top level of the API frame receiver: stream ports, configuration and result register.
// Each input request carries one received serial byte in s_axis_tdata and its
// line-error flag in s_axis_tuser. Each accepted byte yields exactly one result
// request: the event code in m_axis_tuser, and in m_axis_tdata the frame type
// followed by the seven statistics counters.
// A result appears on the output in the cycle after its byte is accepted, and one
// byte is accepted every cycle while the output is not stalled; the frame state and
// counters update on the edge that loads the result register, the only stage.
// While the output holds a result that is not taken, s_axis_tready stays low and
// new bytes wait; it rises again in the cycle the result is taken.
// The cfg channel writes max_frame_length and is always ready; it should only be
// written while no byte is in flight.
// Reset clears the frame state, all counters and the output valid, and sets
// max_frame_length to 255.
module api_frame_receiver_unit
    import afr_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,          // max_frame_length
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,      // rx_byte
    input  logic         s_axis_tuser,      // line_error
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_kind, skipped_count, error_count, overrun_count, bad_checksum_count,
    // unknown_count, retry_total, lost_count
    output logic [231:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser       // event_res
);

    logic                     step;
    logic [15:0]              max_len_reg;
    logic                     out_valid_reg;
    logic [231:0]             out_data_reg;
    logic [2:0]               out_user_reg;
    step_res_t                res;
    logic [COUNTER_WIDTH-1:0] cnt_next [STAT_COUNT];
    logic [223:0]             cnt_flat;
    logic [63:0]              cnt_ext  [STAT_COUNT];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    afr_parser #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (s_axis_tdata),
        .line_error(s_axis_tuser),
        .max_len   (max_len_reg),
        .res       (res),
        .cnt_next  (cnt_next)
    );

    always_comb
    begin
        for (int i = 0; i < STAT_COUNT; i++)
        begin
            cnt_ext[i]            = 64'(cnt_next[i]);
            cnt_flat[i*32 +: 32]  = cnt_ext[i][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {cnt_flat, res.kind};
            out_user_reg <= res.ev;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
